[hdl/zcab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcab_pkg
// Shared types, constants and key schedule functions for the alternate-byte
// ZipCrypto cipher.
// ----------------------------------------------------------------------------
package zcab_pkg;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
    } keys_t;

    localparam logic [31:0] SEED_K0  = 32'h1234_5678;
    localparam logic [31:0] SEED_K1  = 32'h2345_6789;
    localparam logic [31:0] SEED_K2  = 32'h3456_7890;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam int          PASS_LEN = 20;

    localparam logic [7:0] FIXED_PASS [PASS_LEN] = '{
        8'h6F, 8'h66, 8'h4F, 8'h31, 8'h61, 8'h30, 8'h75, 8'h65, 8'h58, 8'h41,
        8'h3F, 8'h20, 8'h5B, 8'hFF, 8'h73, 8'h20, 8'h68, 8'h20, 8'h25, 8'h3F
    };

    localparam logic CIPHER_DECRYPT = 1'b0;
    localparam logic CIPHER_ENCRYPT = 1'b1;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // x * 0x08088405 mod 2^32 as a shift-add
    function automatic logic [31:0] mult_key(input logic [31:0] x);
        return x + (x << 2) + (x << 10) + (x << 15) + (x << 19) + (x << 27);
    endfunction

    function automatic keys_t absorb(input keys_t k, input logic [7:0] b);
        keys_t r;
        r.k0 = crc_byte(k.k0, b);
        r.k1 = mult_key(k.k1 + {24'd0, r.k0[7:0]}) + 32'd1;
        r.k2 = crc_byte(k.k2, r.k1[31:24]);
        return r;
    endfunction

    function automatic keys_t init_keys();
        keys_t k;
        k.k0 = SEED_K0;
        k.k1 = SEED_K1;
        k.k2 = SEED_K2;
        for (int i = 0; i < PASS_LEN; i++) begin
            k = absorb(k, FIXED_PASS[i]);
        end
        return k;
    endfunction

    localparam keys_t KEYS_INIT = init_keys();

endpackage

[hdl/zcab_cipher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcab_cipher_core
// One cipher step: keystream from key 2, XOR, and key absorb of the plain
// byte. Odd-offset words pass through with the keys untouched.
// ----------------------------------------------------------------------------
module zcab_cipher_core
    import zcab_pkg::*;
(
    input  keys_t      keys,
    input  logic       odd_offset,
    input  logic       direction,
    input  logic [7:0] din,
    output logic [7:0] dout,
    output keys_t      keys_next
);

    logic [15:0] v;
    logic [15:0] v_x;
    logic [15:0] prod;
    logic [7:0]  ks;
    logic [7:0]  ciph;
    logic [7:0]  plain;

    assign v     = {keys.k2[15:2], 1'b1, keys.k2[0]};
    assign v_x   = {v[15:1], ~v[0]};
    assign prod  = v * v_x;
    assign ks    = prod[15:8];
    assign ciph  = din ^ ks;
    assign plain = (direction == CIPHER_ENCRYPT) ? din : ciph;

    always_comb begin
        if (odd_offset) begin
            dout      = din;
            keys_next = keys;
        end else begin
            dout      = ciph;
            keys_next = absorb(keys, plain);
        end
    end

endmodule

[hdl/zipcrypto_alternate_byte_cipher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zipcrypto_alternate_byte_cipher_unit
// Alternate-byte ZipCrypto stream cipher, one word per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one buffer byte per word, s_last_in_buffer on the final one.
//   m_ channel: the transformed byte, with m_out_last copied from the input.
//   cfg channel: bit 0 selects decrypt (0) or encrypt (1); always ready.
//   Write it only while no word is in flight.
//   Even-offset bytes are ciphered, odd-offset bytes pass unchanged.
//   The s_ word passes the input register, then the result register, before
//   m_valid rises. Throughput: one word per cycle while m_ready does not
//   stall the output, set by the single key update loop.
//   After the last byte of a buffer the keys and offset parity reload.
//   Reset loads the password-derived keys, even parity and decrypt mode.
//   When m_ready is low the result holds; the input register still takes a
//   word if it is empty, then s_ready drops until the output drains.
// ----------------------------------------------------------------------------
module zipcrypto_alternate_byte_cipher_unit
    import zcab_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_in_buffer,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_cipher_direction
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    keys_t      keys_reg;
    keys_t      keys_next;
    logic       odd_reg;
    logic       dir_reg;
    logic [7:0] core_dout;
    logic       advance;
    logic       fire;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_out_last = out_last_reg;

    zcab_cipher_core u_core (
        .keys       (keys_reg),
        .odd_offset (odd_reg),
        .direction  (dir_reg),
        .din        (in_byte_reg),
        .dout       (core_dout),
        .keys_next  (keys_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            keys_reg      <= KEYS_INIT;
            odd_reg       <= 1'b0;
            dir_reg       <= CIPHER_DECRYPT;
        end else begin
            if (cfg_valid) begin
                dir_reg <= cfg_cipher_direction;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                if (in_last_reg) begin
                    keys_reg <= KEYS_INIT;
                    odd_reg  <= 1'b0;
                end else begin
                    keys_reg <= keys_next;
                    odd_reg  <= ~odd_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_in_buffer;
        end
        if (fire) begin
            out_byte_reg <= core_dout;
            out_last_reg <= in_last_reg;
        end
    end

`ifndef SYNTH
    a_reset_keys: assert property (@(posedge aclk)
        !aresetn |=> (keys_reg == KEYS_INIT) && !odd_reg)
        else $error("keys not reloaded by reset");

    a_last_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_last_reg) |=> (keys_reg == KEYS_INIT) && !odd_reg)
        else $error("keys not reloaded after last word");

    a_odd_keys_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && odd_reg && !in_last_reg) |=> $stable(keys_reg) && !odd_reg)
        else $error("odd word changed the keys");

    a_odd_passthrough: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && odd_reg) |=> (m_out_byte == $past(in_byte_reg)))
        else $error("odd word not passed through");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(keys_reg) && $stable(odd_reg))
        else $error("cipher state moved without a word");
`endif

endmodule
